// ===== sv/order2_nucleotide_freq_model_unit_defines.svh =====
// ----------------------------------------------------------------------------
// order2 nucleotide frequency model - assertion macros
// Concurrent assertion wrappers, empty when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef ORDER2_NUCLEOTIDE_FREQ_MODEL_UNIT_DEFINES_SVH
`define ORDER2_NUCLEOTIDE_FREQ_MODEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define O2NF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("o2nf assertion failed");

// next-cycle implication
`define O2NF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("o2nf assertion failed");

`else

`define O2NF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define O2NF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/o2nf_pkg.sv =====
// ----------------------------------------------------------------------------
// o2nf_pkg
// Widths, constants and shared types of the order-2 base frequency model.
// ----------------------------------------------------------------------------
`default_nettype none

package o2nf_pkg;

   // field widths
   localparam int CHAR_W   = 8;
   localparam int TARGET_W = 16;
   localparam int SYM_W    = 2;
   localparam int LOW_W    = 16;
   localparam int CNT_W    = 17;

   // model geometry
   localparam int NUM_SYMS = 4;
   localparam int NUM_CTX  = 16;
   localparam int CTX_W    = 4;
   localparam int ROW_W    = NUM_SYMS * CNT_W;
   // four counts of CNT_W bits sum without overflow in this width
   localparam int TOT_W    = CNT_W + 2;

   // halve a context once its total passes this
   localparam int unsigned TOTAL_LIMIT = 32'd65536;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // base codes
   typedef enum logic [SYM_W-1:0] {
      BASE_A = 2'd0,
      BASE_C = 2'd1,
      BASE_G = 2'd2,
      BASE_T = 2'd3
   } base_type;

   typedef logic [CNT_W-1:0] count_type;
   typedef count_type [NUM_SYMS-1:0] row_type;

   // classified item travelling from front to back
   typedef struct packed {
      logic                decode;
      logic                sos;
      logic                skip;
      base_type            code;
      logic [TARGET_W-1:0] target;
   } item_type;

   // result without the total of the following context
   typedef struct packed {
      logic             symbol_valid;
      logic [SYM_W-1:0] symbol;
      logic [LOW_W-1:0] cum_low;
      count_type        sym_freq;
      count_type        ctx_total;
   } pend_type;

endpackage

`default_nettype wire

// ===== sv/o2nf_req_if.sv =====
// ----------------------------------------------------------------------------
// o2nf_req_if
// Request channel: one base character or one decoder target per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface o2nf_req_if;
   import o2nf_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic                start_of_stream;
   logic [CHAR_W-1:0]   base_char;
   logic [TARGET_W-1:0] target;

   modport source (
      output valid, req_type, start_of_stream, base_char, target,
      input  ready
   );

   modport sink (
      input  valid, req_type, start_of_stream, base_char, target,
      output ready
   );

endinterface

`default_nettype wire

// ===== sv/o2nf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// o2nf_rsp_if
// Response channel: coder interval and totals, one transaction per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface o2nf_rsp_if;
   import o2nf_pkg::*;

   logic             valid;
   logic             ready;
   logic             symbol_valid;
   logic [SYM_W-1:0] symbol;
   logic [LOW_W-1:0] cum_low;
   logic [CNT_W-1:0] sym_freq;
   logic [CNT_W-1:0] ctx_total;
   logic [CNT_W-1:0] next_total;

   modport source (
      output valid, symbol_valid, symbol, cum_low, sym_freq, ctx_total, next_total,
      input  ready
   );

   modport sink (
      input  valid, symbol_valid, symbol, cum_low, sym_freq, ctx_total, next_total,
      output ready
   );

endinterface

`default_nettype wire

// ===== sv/o2nf_ram.sv =====
// ----------------------------------------------------------------------------
// o2nf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module o2nf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/o2nf_front.sv =====
// ----------------------------------------------------------------------------
// o2nf_front
// Accepts request transactions and classifies them for the model engine.
// ----------------------------------------------------------------------------
`default_nettype none

module o2nf_front (
   o2nf_req_if.sink              req_ch,
   output logic                  push_valid,
   output o2nf_pkg::item_type    push_item,
   input  wire logic             push_ready
);
   import o2nf_pkg::*;

   base_type code;
   logic     is_base;

   // map ascii to a base code, either case
   always_comb begin
      code    = BASE_A;
      is_base = 1'b1;
      case (req_ch.base_char)
         8'h41, 8'h61: code = BASE_A;   // A a
         8'h43, 8'h63: code = BASE_C;   // C c
         8'h47, 8'h67: code = BASE_G;   // G g
         8'h54, 8'h74: code = BASE_T;   // T t
         default:      is_base = 1'b0;
      endcase
   end

   // build the queue entry
   always_comb begin
      push_item.decode = req_ch.req_type;
      push_item.sos    = req_ch.start_of_stream;
      push_item.skip   = !req_ch.req_type && !is_base;
      push_item.code   = code;
      push_item.target = req_ch.target;
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

`default_nettype wire

// ===== sv/o2nf_fifo.sv =====
// ----------------------------------------------------------------------------
// o2nf_fifo
// Short queue of classified items between the front and the model engine.
// ----------------------------------------------------------------------------
`default_nettype none

module o2nf_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire o2nf_pkg::item_type push_item,
   output logic                  push_ready,
   output logic                  pop_valid,
   output o2nf_pkg::item_type    pop_item,
   input  wire logic             pop_ready
);
   import o2nf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff,  count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_QW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/o2nf_back.sv =====
// ----------------------------------------------------------------------------
// o2nf_back
// Model engine: codes one item per cycle while the response side keeps up, against
// the current context row, updates the counts and presents the coder interval.
// ----------------------------------------------------------------------------
`default_nettype none
`include "order2_nucleotide_freq_model_unit_defines.svh"

module o2nf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire o2nf_pkg::item_type item,
   output logic                    item_ready,
   o2nf_rsp_if.source              rsp_ch
);
   import o2nf_pkg::*;

   localparam row_type ONES_ROW = {NUM_SYMS{CNT_W'(1)}};

   // context state
   logic [NUM_CTX-1:0] valid_ff,  valid_in;
   logic [CTX_W-1:0]   ctx_ff,    ctx_in;
   logic               bypass_ff, bypass_in;
   row_type            fwd_row_ff;

   // pending result and output register
   logic      p_valid_ff, p_valid_in;
   pend_type  p_ff;
   logic      o_valid_ff, o_valid_in;
   pend_type  o_ff;
   count_type o_next_ff;

   // row memory
   row_type          ram_rdata;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [CTX_W-1:0] next_ctx;

   // datapath
   row_type          cur_row, eff_row, upd_row, new_row;
   logic [TOT_W-1:0] cur_total;
   logic [TOT_W-1:0] run [NUM_SYMS];
   logic [TOT_W-1:0] total;
   logic [CTX_W-1:0] eff_ctx;
   logic [SYM_W-1:0] dec_sym, sym;
   logic [LOW_W-1:0] low;
   count_type        freq;
   logic             halve;
   logic [CNT_W:0]   half_sum;
   count_type        half_cnt;
   logic             process_en, p_drain;
   pend_type         p_in;

   // handshake between stages
   assign p_drain    = p_valid_ff && (!o_valid_ff || rsp_ch.ready);
   assign process_en = item_valid && (!p_valid_ff || p_drain);
   assign item_ready = !p_valid_ff || p_drain;

   // current context row: forwarded, from memory, or untouched since a clear
   always_comb begin
      if (bypass_ff) begin
         cur_row = fwd_row_ff;
      end else if (valid_ff[ctx_ff]) begin
         cur_row = ram_rdata;
      end else begin
         cur_row = ONES_ROW;
      end
      cur_total = '0;
      for (int i = 0; i < NUM_SYMS; i++) begin
         cur_total = cur_total + TOT_W'(cur_row[i]);
      end
   end

   // running sums over the effective row
   always_comb begin
      eff_row = item.sos ? ONES_ROW : cur_row;
      eff_ctx = item.sos ? '0 : ctx_ff;
      run[0]  = TOT_W'(eff_row[0]);
      for (int i = 1; i < NUM_SYMS; i++) begin
         run[i] = run[i-1] + TOT_W'(eff_row[i]);
      end
      total = run[NUM_SYMS-1];
   end

   // decode: lowest symbol whose running sum passes the target, else A
   always_comb begin
      dec_sym = SYM_W'(BASE_A);
      for (int i = NUM_SYMS - 1; i >= 0; i--) begin
         if (run[i] > TOT_W'(item.target)) begin
            dec_sym = SYM_W'(i);
         end
      end
      sym = item.decode ? dec_sym : SYM_W'(item.code);
   end

   // interval of the chosen symbol
   always_comb begin
      case (sym)
         SYM_W'(BASE_A): low = '0;
         SYM_W'(BASE_C): low = run[0][LOW_W-1:0];
         SYM_W'(BASE_G): low = run[1][LOW_W-1:0];
         SYM_W'(BASE_T): low = run[2][LOW_W-1:0];
         default:        low = '0;
      endcase
      freq = eff_row[sym];
   end

   // increment, then halve the whole context once it grows past the limit
   always_comb begin
      upd_row      = eff_row;
      upd_row[sym] = freq + CNT_W'(1);
      halve        = (32'(total) + 32'd1) > TOTAL_LIMIT;
      new_row      = upd_row;
      half_sum     = '0;
      half_cnt     = '0;
      if (halve) begin
         for (int i = 0; i < NUM_SYMS; i++) begin
            half_sum   = {1'b0, upd_row[i]} + (CNT_W+1)'(1);
            half_cnt   = half_sum[CNT_W:1];
            new_row[i] = (half_cnt == '0) ? CNT_W'(1) : half_cnt;
         end
      end
      next_ctx = {eff_ctx[CTX_W-SYM_W-1:0], sym};
   end

   // memory access: write back the row, fetch the next one unless it is the same
   assign ram_wr_en = process_en && !item.skip;
   assign ram_rd_en = process_en && !item.skip && (next_ctx != eff_ctx);

   o2nf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_CTX)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (eff_ctx),
      .wr_data (new_row),
      .rd_en   (ram_rd_en),
      .rd_addr (next_ctx),
      .rd_data (ram_rdata)
   );

   // result of this item
   always_comb begin
      if (item.skip) begin
         p_in.symbol_valid = 1'b0;
         p_in.symbol       = '0;
         p_in.cum_low      = '0;
         p_in.sym_freq     = '0;
      end else begin
         p_in.symbol_valid = 1'b1;
         p_in.symbol       = sym;
         p_in.cum_low      = low;
         p_in.sym_freq     = freq;
      end
      p_in.ctx_total = total[CNT_W-1:0];
   end

   // next state of context tracking and stage flags
   always_comb begin
      valid_in   = valid_ff;
      ctx_in     = ctx_ff;
      bypass_in  = bypass_ff;
      p_valid_in = p_valid_ff;
      o_valid_in = o_valid_ff;
      if (process_en) begin
         if (item.sos) begin
            valid_in  = '0;
            bypass_in = 1'b0;
         end
         if (item.skip) begin
            ctx_in = eff_ctx;
         end else begin
            valid_in  = valid_in | (NUM_CTX'(1) << eff_ctx);
            ctx_in    = next_ctx;
            bypass_in = (next_ctx == eff_ctx);
         end
      end
      if (process_en) begin
         p_valid_in = 1'b1;
      end else if (p_drain) begin
         p_valid_in = 1'b0;
      end
      if (p_drain) begin
         o_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         ctx_ff     <= '0;
         bypass_ff  <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         ctx_ff     <= ctx_in;
         bypass_ff  <= bypass_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (process_en && !item.skip) begin
         fwd_row_ff <= new_row;
      end
      if (process_en) begin
         p_ff <= p_in;
      end
      if (p_drain) begin
         o_ff      <= p_ff;
         o_next_ff <= cur_total[CNT_W-1:0];
      end
   end

   // response channel
   assign rsp_ch.valid        = o_valid_ff;
   assign rsp_ch.symbol_valid = o_ff.symbol_valid;
   assign rsp_ch.symbol       = o_ff.symbol;
   assign rsp_ch.cum_low      = o_ff.cum_low;
   assign rsp_ch.sym_freq     = o_ff.sym_freq;
   assign rsp_ch.ctx_total    = o_ff.ctx_total;
   assign rsp_ch.next_total   = o_next_ff;

   // checks
   `O2NF_ASSERT_IMPL(a_bypass_row_valid, clock, reset, bypass_ff, valid_ff[ctx_ff])
   `O2NF_ASSERT_NXT(a_written_row_valid, clock, reset, ram_wr_en, valid_ff[$past(eff_ctx)])
   `O2NF_ASSERT_IMPL(a_context_total_min, clock, reset, p_valid_ff, cur_total >= TOT_W'(NUM_SYMS))
   `O2NF_ASSERT_NXT(a_pending_held, clock, reset, p_valid_ff && !p_drain, p_valid_ff)

endmodule

`default_nettype wire

// ===== sv/order2_nucleotide_freq_model_unit.sv =====
// ----------------------------------------------------------------------------
// order2_nucleotide_freq_model_unit
// Adaptive order-2 base frequency model for a range coder.
// ----------------------------------------------------------------------------
// Takes one request transaction per clock when nothing stalls and gives one response
// transaction for each, in order, after it has passed the queue, the pending stage and
// the output register. The rate is set by the context loop in the model engine: each
// item reads its context row, decodes or encodes, increments and, if needed, halves
// the row combinationally, while the row of the following context is fetched from the
// row memory and forwarded straight into the next item. A two-entry queue after the
// character classifier and a pending stage before the output register let the
// request and response sides stall independently. Reset and start_of_stream
// restore all counts at once through per-context valid bits; no clearing pass.
`default_nettype none

module order2_nucleotide_freq_model_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   o2nf_req_if.sink   req_ch,
   o2nf_rsp_if.source rsp_ch
);
   import o2nf_pkg::*;

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   // classify incoming characters
   o2nf_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // queue between front and engine
   o2nf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // model engine
   o2nf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_ready (pop_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== dv/order2_nucleotide_freq_model_unit_test.sv =====
// ----------------------------------------------------------------------------
// order2_nucleotide_freq_model_unit_test
// Self-checking bench for the order-2 base frequency model. A directed table
// covers the corner cases, then random base streams follow. Last comes a
// closing stream, mostly A, with no idling on either side. Every response is checked,
// against the table for fixed rows and otherwise against an in-bench copy of the counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module order2_nucleotide_freq_model_unit_test;
   import o2nf_pkg::*;

   localparam int          RANDOM_ITEMS   = 1400;
   localparam int          TAIL_ITEMS     = 230;
   localparam int          PRESSURE_AT    = 600;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          DRAIN_CYCLES   = 12;
   localparam int          CYCLE_LIMIT    = 1000000;
   localparam int          REPORT_CAP     = 100;
   localparam logic [7:0]  CASE_BIT       = 8'h20;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } coder_op_type;

   typedef struct packed {
      coder_op_type        op;
      logic                sos;
      logic [CHAR_W-1:0]   chr;
      logic [TARGET_W-1:0] target;
   } req_item_type;

   typedef struct packed {
      logic             symbol_valid;
      base_type         symbol;
      logic [LOW_W-1:0] cum_low;
      count_type        sym_freq;
      count_type        ctx_total;
      count_type        next_total;
   } coder_rsp_type;

   typedef struct packed {
      req_item_type  item;
      logic          fixed;
      coder_rsp_type rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   o2nf_req_if req_ch ();
   o2nf_rsp_if rsp_ch ();

   order2_nucleotide_freq_model_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the context counts
   count_type         base_count [NUM_CTX*NUM_SYMS];
   logic [CTX_W-1:0]  history_ctx;
   coder_rsp_type     interval_queue [$];

   int   fail_count;
   int   taken_count;
   int   rsp_count;
   int   encode_count;
   int   decode_count;
   int   skip_count;
   int   halvings;
   int   cycle_count;
   logic quiet;
   int   tx_gap_pct;
   int   rx_gap_pct;

   // corner cases; rows with fixed set carry their expected interval
   directed_row_type directed_rows [22] = '{
      '{'{OP_ENCODE, 1'b1, "A", 16'h0000}, 1'b1,
        '{1'b1, BASE_A, 16'd0, 17'd1, 17'd4, 17'd5}},
      '{'{OP_ENCODE, 1'b0, 8'h00, 16'h0000}, 1'b1,
        '{1'b0, BASE_A, 16'd0, 17'd0, 17'd5, 17'd5}},
      '{'{OP_ENCODE, 1'b0, 8'hFF, 16'hFFFF}, 1'b1,
        '{1'b0, BASE_A, 16'd0, 17'd0, 17'd5, 17'd5}},
      '{'{OP_ENCODE, 1'b0, "t", 16'h0000}, 1'b1,
        '{1'b1, BASE_T, 16'd4, 17'd1, 17'd5, 17'd4}},
      '{'{OP_ENCODE, 1'b0, "c", 16'h0000}, 1'b1,
        '{1'b1, BASE_C, 16'd1, 17'd1, 17'd4, 17'd4}},
      '{'{OP_ENCODE, 1'b0, "G", 16'h0000}, 1'b1,
        '{1'b1, BASE_G, 16'd2, 17'd1, 17'd4, 17'd4}},
      '{'{OP_ENCODE, 1'b0, "a", 16'h0000}, 1'b1,
        '{1'b1, BASE_A, 16'd0, 17'd1, 17'd4, 17'd4}},
      '{'{OP_ENCODE, 1'b0, "g", 16'hFFFF}, 1'b0, '0},
      '{'{OP_ENCODE, 1'b0, "C", 16'h5555}, 1'b0, '0},
      '{'{OP_ENCODE, 1'b0, "T", 16'hAAAA}, 1'b0, '0},
      '{'{OP_ENCODE, 1'b0, "N", 16'h0000}, 1'b0, '0},
      '{'{OP_ENCODE, 1'b0, 8'h80, 16'h0000}, 1'b0, '0},
      '{'{OP_DECODE, 1'b0, "x", 16'h0000}, 1'b0, '0},
      '{'{OP_DECODE, 1'b0, 8'hFF, 16'hFFFF}, 1'b0, '0},
      '{'{OP_DECODE, 1'b1, 8'h00, 16'd3}, 1'b1,
        '{1'b1, BASE_T, 16'd3, 17'd1, 17'd4, 17'd4}},
      '{'{OP_DECODE, 1'b0, "G", 16'd4}, 1'b1,
        '{1'b1, BASE_A, 16'd0, 17'd1, 17'd4, 17'd4}},
      '{'{OP_DECODE, 1'b0, "C", 16'd0}, 1'b1,
        '{1'b1, BASE_A, 16'd0, 17'd1, 17'd4, 17'd5}},
      '{'{OP_DECODE, 1'b0, "T", 16'd1}, 1'b1,
        '{1'b1, BASE_C, 16'd1, 17'd1, 17'd5, 17'd4}},
      '{'{OP_DECODE, 1'b1, 8'h7F, 16'h8000}, 1'b1,
        '{1'b1, BASE_A, 16'd0, 17'd1, 17'd4, 17'd5}},
      '{'{OP_ENCODE, 1'b1, "?", 16'h0000}, 1'b1,
        '{1'b0, BASE_A, 16'd0, 17'd0, 17'd4, 17'd4}},
      '{'{OP_ENCODE, 1'b0, "A", 16'hFFFF}, 1'b0, '0},
      '{'{OP_DECODE, 1'b0, "A", 16'd5}, 1'b0, '0}
   };

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // all counts back to one, history to the empty context
   function automatic void clear_counts();
      int i;
      for (i = 0; i < NUM_CTX*NUM_SYMS; i++) base_count[i] = count_type'(1);
      history_ctx = '0;
   endfunction

   function automatic logic [TOT_W-1:0] row_total(input logic [CTX_W-1:0] ctx);
      logic [TOT_W-1:0] sum;
      int i;
      sum = '0;
      for (i = 0; i < NUM_SYMS; i++) sum += TOT_W'(base_count[ctx*NUM_SYMS + i]);
      return sum;
   endfunction

   // either case of A, C, G, T maps to a base
   function automatic logic char_to_base(input logic [CHAR_W-1:0] c, output base_type b);
      b = BASE_A;
      case (c | CASE_BIT)
         "a": begin b = BASE_A; return 1'b1; end
         "c": begin b = BASE_C; return 1'b1; end
         "g": begin b = BASE_G; return 1'b1; end
         "t": begin b = BASE_T; return 1'b1; end
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] char_from_base(input base_type b);
      logic [CHAR_W-1:0] c;
      case (b)
         BASE_A:  c = "A";
         BASE_C:  c = "C";
         BASE_G:  c = "G";
         default: c = "T";
      endcase
      if ($urandom_range(0, 1) != 0) c = c | CASE_BIT;
      return c;
   endfunction

   // decoder target that lands inside the interval of base b in the current context
   function automatic logic [TARGET_W-1:0] pick_target(input base_type b);
      logic [TOT_W-1:0] low;
      int unsigned row;
      int i;
      row = history_ctx * NUM_SYMS;
      low = '0;
      for (i = 0; i < int'(b); i++) low += TOT_W'(base_count[row + i]);
      low = low + TOT_W'($urandom_range(0, base_count[row + b] - 1));
      return low[TARGET_W-1:0];
   endfunction

   // coder interval of one transaction, then count update and context shift
   task automatic code_step(input req_item_type it, output coder_rsp_type r);
      logic [TOT_W-1:0] total;
      logic [TOT_W-1:0] run;
      logic [TOT_W-1:0] low;
      logic [TOT_W-1:0] half;
      int unsigned      row;
      base_type         sym;
      logic             found;
      int               i;
      r = '0;
      if (it.sos) clear_counts();
      row   = history_ctx * NUM_SYMS;
      total = row_total(history_ctx);
      if (it.op == OP_ENCODE) begin
         // not a base: nothing changes
         if (!char_to_base(it.chr, sym)) begin
            r.ctx_total  = total[CNT_W-1:0];
            r.next_total = total[CNT_W-1:0];
            return;
         end
      end else begin
         // target past the total falls back to A
         sym   = BASE_A;
         run   = '0;
         found = 1'b0;
         for (i = 0; i < NUM_SYMS; i++) begin
            if (!found) begin
               run += TOT_W'(base_count[row + i]);
               if (run > it.target) begin
                  sym   = base_type'(i);
                  found = 1'b1;
               end
            end
         end
      end
      low = '0;
      for (i = 0; i < int'(sym); i++) low += TOT_W'(base_count[row + i]);
      r.symbol_valid = 1'b1;
      r.symbol       = sym;
      r.cum_low      = low[LOW_W-1:0];
      r.sym_freq     = base_count[row + sym];
      r.ctx_total    = total[CNT_W-1:0];
      base_count[row + sym] = base_count[row + sym] + 1'b1;
      // halve the row once the total passes the limit
      if (total + 1 > TOTAL_LIMIT) begin
         halvings++;
         for (i = 0; i < NUM_SYMS; i++) begin
            half = TOT_W'(base_count[row + i]);
            half = TOT_W'((half + 1) >> 1);
            base_count[row + i] = (half == 0) ? count_type'(1) : half[CNT_W-1:0];
         end
      end
      history_ctx = {history_ctx[CTX_W-3:0], sym};
      total       = row_total(history_ctx);
      r.next_total = total[CNT_W-1:0];
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_CAP)
            $display("%0t: response %0d %s expected %0h, got %0h",
                     $time, rsp_count, field, want, got);
      end
   endtask

   // offer one transaction, optionally after an idle burst, and log its interval
   task automatic offer_item(input req_item_type it, input logic fixed,
                             input coder_rsp_type typed);
      coder_rsp_type want;
      if (!quiet && tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.req_type        <= it.op;
      req_ch.start_of_stream <= it.sos;
      req_ch.base_char       <= it.chr;
      req_ch.target          <= it.target;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      code_step(it, want);
      if (fixed) want = typed;
      interval_queue.push_back(want);
      taken_count++;
      if (!want.symbol_valid) skip_count++;
      else if (it.op == OP_DECODE) decode_count++;
      else encode_count++;
      @(negedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      req_item_type it;
      base_type     b;
      int           k;
      int           n;
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.req_type        = OP_ENCODE;
      req_ch.start_of_stream = 1'b0;
      req_ch.base_char       = '0;
      req_ch.target          = '0;
      quiet      = 1'b0;
      tx_gap_pct = 0;
      rx_gap_pct = 0;
      clear_counts();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (n = 0; n < $size(directed_rows); n++)
         offer_item(directed_rows[n].item, directed_rows[n].fixed, directed_rows[n].rsp);

      // random streams, mostly real bases with some noise
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 128 == 0) begin
            case ($urandom_range(0, 3))
               0: begin tx_gap_pct = 0;  rx_gap_pct = 0;  end
               1: begin tx_gap_pct = 10; rx_gap_pct = 10; end
               2: begin tx_gap_pct = 30; rx_gap_pct = 5;  end
               default: begin tx_gap_pct = 5; rx_gap_pct = 30; end
            endcase
         end
         it.sos    = ($urandom_range(0, 49) == 0);
         it.chr    = 8'($urandom_range(0, 255));
         it.target = 16'($urandom_range(0, 65535));
         b         = base_type'($urandom_range(0, NUM_SYMS-1));
         k         = $urandom_range(0, 15);
         if (k <= 8) begin
            it.op  = OP_ENCODE;
            it.chr = char_from_base(b);
         end else if (k <= 12) begin
            it.op     = OP_DECODE;
            it.target = it.sos ? 16'($urandom_range(0, NUM_SYMS-1)) : pick_target(b);
         end else if (k == 13) begin
            it.op     = OP_DECODE;
            it.target = 16'($urandom_range(it.sos ? NUM_SYMS : int'(row_total(history_ctx)),
                                           65535));
         end else if (k == 14) begin
            it.op = OP_ENCODE;
         end else begin
            it.op = OP_ENCODE;
            while (char_to_base(it.chr, b)) it.chr = 8'($urandom_range(0, 255));
         end
         offer_item(it, 1'b0, '0);
      end

      // closing stream, mostly A, with no idling on either side
      quiet = 1'b1;
      it    = '{OP_ENCODE, 1'b1, "A", 16'h0000};
      offer_item(it, 1'b0, '0);
      for (n = 0; n < TAIL_ITEMS; n++) begin
         b         = ($urandom_range(0, 7) == 0) ? base_type'($urandom_range(0, NUM_SYMS-1))
                                                 : BASE_A;
         it.sos    = 1'b0;
         it.op     = ($urandom_range(0, 1) != 0) ? OP_DECODE : OP_ENCODE;
         it.chr    = (it.op == OP_ENCODE) ? char_from_base(b) : 8'($urandom_range(0, 255));
         it.target = (it.op == OP_DECODE) ? pick_target(b) : 16'($urandom_range(0, 65535));
         offer_item(it, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      // drain
      while (interval_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("coded %0d transactions: %0d encodes, %0d decodes, %0d skipped characters",
               taken_count, encode_count, decode_count, skip_count);
      $display("%0d context halvings, one %0d-cycle response hold-off, %0d mismatches",
               halvings, HOLD_CYCLES, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // response side back-pressure: random bursts and one long hold-off
   initial begin : response_ready
      int  stall_left;
      logic held;
      stall_left   = 0;
      held         = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0)
            stall_left--;
         else if (!quiet && !held && taken_count >= PRESSURE_AT) begin
            stall_left = HOLD_CYCLES;
            held       = 1'b1;
         end else if (!quiet && rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct)
            stall_left = $urandom_range(1, 14);
         rsp_ch.ready <= (stall_left == 0) && !reset;
      end
   end

   // response check against the oldest logged interval
   always @(posedge clock) begin : response_check
      coder_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_count++;
         if (interval_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
               $display("%0t: response %0d expected none, got symbol %0h total %0h",
                        $time, rsp_count, rsp_ch.symbol, rsp_ch.ctx_total);
         end else begin
            want = interval_queue.pop_front();
            check_field("symbol_valid", want.symbol_valid, rsp_ch.symbol_valid);
            check_field("symbol", want.symbol, rsp_ch.symbol);
            check_field("cum_low", want.cum_low, rsp_ch.cum_low);
            check_field("sym_freq", want.sym_freq, rsp_ch.sym_freq);
            check_field("ctx_total", want.ctx_total, rsp_ch.ctx_total);
            check_field("next_total", want.next_total, rsp_ch.next_total);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
